/* rtl/nibcpu_pkg.sv */
// ----------------------------------------------------------------------------
// nibcpu_pkg
// Shared types, opcodes and helpers for the nibble cpu jump and register
// executor.
// ----------------------------------------------------------------------------
package nibcpu_pkg;

  localparam int STACK_DEPTH = 3;
  localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int ADDR_W = 12;
  localparam int NIB_W  = 4;
  localparam int WORD_W = 8;
  localparam int PAIR_W = 3;

  typedef enum logic [3:0] {
    OP_NOP     = 4'h0,
    OP_JCN     = 4'h1,
    OP_FIM_SRC = 4'h2,
    OP_FIN_JIN = 4'h3,
    OP_JUN     = 4'h4,
    OP_JMS     = 4'h5,
    OP_INC     = 4'h6,
    OP_ISZ     = 4'h7
  } opcode_t;

  localparam logic [1:0] WK_NONE   = 2'd0;
  localparam logic [1:0] WK_SINGLE = 2'd1;
  localparam logic [1:0] WK_PAIR   = 2'd2;

  // jcn condition bits
  localparam int JCN_INV  = 3;
  localparam int JCN_ACCZ = 2;
  localparam int JCN_CY   = 1;
  localparam int JCN_TST  = 0;

  typedef struct packed {
    logic [WORD_W-1:0] instruction_word;
    logic [NIB_W-1:0]  accumulator;
    logic              carry;
    logic              test_pin;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_address;
    logic [1:0]        write_kind;
    logic [NIB_W-1:0]  target_register;
    logic [NIB_W-1:0]  value_high;
    logic [NIB_W-1:0]  value_low;
    logic              took_jump;
    logic              awaiting_second;
  } out_item_t;

  // control from the execute logic to the state registers
  typedef struct packed {
    out_item_t         result;
    logic              pending_nxt;
    logic              rf_we;
    logic [WORD_W-1:0] rf_wdata;
    logic              push;
    logic [ADDR_W-1:0] push_addr;
  } exec_t;

  function automatic logic is_two_word(input logic [WORD_W-1:0] w);
    logic [3:0] op;
    op = w[7:4];
    case (op)
      OP_JCN, OP_JUN, OP_JMS, OP_ISZ: is_two_word = 1'b1;
      OP_FIM_SRC:                     is_two_word = ~w[0];
      default:                        is_two_word = 1'b0;
    endcase
  endfunction

endpackage

/* rtl/nibcpu_exec.sv */
// ----------------------------------------------------------------------------
// nibcpu_exec
// Combinational execute step: decodes one word against the current machine
// state and produces the result item and the state updates.
// ----------------------------------------------------------------------------
module nibcpu_exec import nibcpu_pkg::*; (
  input  in_item_t          item,
  input  logic              pending,
  input  logic [WORD_W-1:0] first_word,
  input  logic [ADDR_W-1:0] pc,
  input  logic [WORD_W-1:0] pair_data,
  output logic [PAIR_W-1:0] pair_sel,
  output exec_t             exec
);

  logic [ADDR_W-1:0] after;
  logic [WORD_W-1:0] op_word;
  logic [3:0]        op;
  logic [3:0]        arg;
  logic [NIB_W-1:0]  nib;
  logic [NIB_W-1:0]  inc;
  logic [WORD_W-1:0] single_wdata;
  logic              jcn_cond;
  logic [WORD_W-1:0] word;

  assign word     = item.instruction_word;
  assign after    = pc + ADDR_W'(1);
  assign op_word  = pending ? first_word : word;
  assign op       = op_word[7:4];
  assign arg      = op_word[3:0];
  assign pair_sel = arg[3:1];

  assign nib = arg[0] ? pair_data[3:0] : pair_data[7:4];
  assign inc = nib + NIB_W'(1);
  assign single_wdata = arg[0] ? {pair_data[7:4], inc} : {inc, pair_data[3:0]};

  assign jcn_cond = arg[JCN_INV] ^
                    ((arg[JCN_ACCZ] && (item.accumulator == '0)) ||
                     (arg[JCN_CY] && item.carry) ||
                     (arg[JCN_TST] && !item.test_pin));

  always_comb begin
    exec = '0;
    exec.result.next_address = after;
    exec.push_addr = after;
    if (pending) begin
      case (op)
        OP_JCN: begin
          if (jcn_cond) begin
            exec.result.next_address = {after[11:8], word};
            exec.result.took_jump    = 1'b1;
          end
        end
        OP_FIM_SRC: begin
          exec.result.write_kind      = WK_PAIR;
          exec.result.target_register = {arg[3:1], 1'b0};
          exec.result.value_high      = word[7:4];
          exec.result.value_low       = word[3:0];
          exec.rf_we    = 1'b1;
          exec.rf_wdata = word;
        end
        OP_JUN, OP_JMS: begin
          exec.push                = (op == OP_JMS);
          exec.result.next_address = {arg, word};
          exec.result.took_jump    = 1'b1;
        end
        OP_ISZ: begin
          exec.result.write_kind      = WK_SINGLE;
          exec.result.target_register = arg;
          exec.result.value_low       = inc;
          exec.rf_we    = 1'b1;
          exec.rf_wdata = single_wdata;
          if (inc != '0) begin
            exec.result.next_address = {after[11:8], word};
            exec.result.took_jump    = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (is_two_word(word)) begin
      exec.pending_nxt            = 1'b1;
      exec.result.awaiting_second = 1'b1;
    end else begin
      case (op)
        OP_FIN_JIN: begin
          // jin: page from the address after this word, offset from the pair
          if (arg[0]) begin
            exec.result.next_address = {after[11:8], pair_data};
            exec.result.took_jump    = 1'b1;
          end
        end
        OP_INC: begin
          exec.result.write_kind      = WK_SINGLE;
          exec.result.target_register = arg;
          exec.result.value_low       = inc;
          exec.rf_we    = 1'b1;
          exec.rf_wdata = single_wdata;
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/nibble_cpu_jump_and_register_executor.sv */
// ----------------------------------------------------------------------------
// nibble_cpu_jump_and_register_executor
// Executes one instruction word per transfer and reports the next fetch
// address, any index register write and jump status.
// ----------------------------------------------------------------------------
// One instruction word is taken per cycle unless the input side stalls. The
// word lands in an input register, the execute logic reads the program
// counter, the addressed index register pair and the pending first word,
// and the result is captured in the output register in the same cycle that
// the state is updated. The sixteen index registers are held as eight pairs
// with one read and one write per cycle. The input side stalls only while
// both the input and the output registers are full and the output is
// stalled.
module nibble_cpu_jump_and_register_executor import nibcpu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic              s1_valid_r;
  in_item_t          in_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic [ADDR_W-1:0] pc_r;
  logic [WORD_W-1:0] pairs_r [8];
  logic [ADDR_W-1:0] stack_r [STACK_DEPTH];
  logic [SP_W-1:0]   sp_r;
  logic [SP_W-1:0]   sp_nxt;
  logic              pending_r;
  logic [WORD_W-1:0] first_word_r;

  logic              s2_ready;
  logic              s1_fire;
  logic              in_fire;
  logic [PAIR_W-1:0] pair_sel;
  exec_t             exec;

  assign s2_ready  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && s2_ready;
  assign in_stall  = s1_valid_r && !s2_ready;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign sp_nxt = (sp_r == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_r + SP_W'(1);

  nibcpu_exec u_exec (
    .item       (in_item_r),
    .pending    (pending_r),
    .first_word (first_word_r),
    .pc         (pc_r),
    .pair_data  (pairs_r[pair_sel]),
    .pair_sel   (pair_sel),
    .exec       (exec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r <= in_item;
    end
    if (s1_fire) begin
      out_item_r <= exec.result;
    end
  end

  // machine state moves once per executed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= '0;
      sp_r         <= '0;
      pending_r    <= 1'b0;
      first_word_r <= '0;
      for (int i = 0; i < 8; i++) begin
        pairs_r[i] <= '0;
      end
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack_r[i] <= '0;
      end
    end else if (s1_fire) begin
      pc_r      <= exec.result.next_address;
      pending_r <= exec.pending_nxt;
      if (exec.pending_nxt) begin
        first_word_r <= in_item_r.instruction_word;
      end
      if (exec.rf_we) begin
        pairs_r[pair_sel] <= exec.rf_wdata;
      end
      if (exec.push) begin
        stack_r[sp_r] <= exec.push_addr;
        sp_r          <= sp_nxt;
      end
    end
  end

  a_write_kind_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.write_kind == WK_NONE ||
                     out_item_r.write_kind == WK_SINGLE ||
                     out_item_r.write_kind == WK_PAIR))
    else $error("illegal write kind on result");

  a_first_word_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.awaiting_second |->
      !out_item_r.took_jump && out_item_r.write_kind == WK_NONE)
    else $error("first word of a two-word instruction did work");

  a_pair_even : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.write_kind == WK_PAIR |->
      !out_item_r.target_register[0])
    else $error("pair write to odd register");

  a_pending_follows : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && exec.result.awaiting_second |=> pending_r)
    else $error("pending second word not recorded");

  a_pc_tracks_result : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> pc_r == out_item_r.next_address)
    else $error("program counter differs from reported next address");

endmodule

/* tb/tb_nibble_cpu_jump_and_register_executor.sv */
// ----------------------------------------------------------------------------
// tb_nibble_cpu_jump_and_register_executor
// Streams instruction words into the executor and compares every result with
// an in-bench model of the program counter, index registers, call stack and
// two-word decode. Both sides idle and stall at random, with bursts and drains.
// ----------------------------------------------------------------------------
module tb_nibble_cpu_jump_and_register_executor;
  import nibcpu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  nibble_cpu_jump_and_register_executor u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // model state
  logic [ADDR_W-1:0] pc_q = '0;
  logic [NIB_W-1:0]  idx_regs [16];
  logic [ADDR_W-1:0] call_stack [STACK_DEPTH];
  int                call_sp = 0;
  logic              second_due = 1'b0;
  logic [WORD_W-1:0] held_first = '0;

  out_item_t predicted_q [$];
  out_item_t want;
  out_item_t held_item;
  logic      held_stalled = 1'b0;
  bit        no_idle = 1'b0;
  int        stall_left = 0;
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_jumps = 0;
  int        n_page_end_jumps = 0;
  int        n_reg_writes = 0;

  initial begin
    foreach (idx_regs[i]) idx_regs[i] = '0;
    foreach (call_stack[i]) call_stack[i] = '0;
  end

  // advances the model by one instruction word and returns its result
  function automatic out_item_t execute_word(input in_item_t it);
    out_item_t         r;
    logic [ADDR_W-1:0] nxt;
    logic [WORD_W-1:0] w;
    logic [3:0]        op;
    logic [3:0]        arg;
    logic [3:0]        v;
    logic [3:0]        ev;
    logic              cond;
    logic              rel_jump;
    r = '0;
    w = it.instruction_word;
    nxt = pc_q + 12'd1;
    rel_jump = 1'b0;
    if (second_due) begin
      op = held_first[7:4];
      arg = held_first[3:0];
      second_due = 1'b0;
      case (op)
        OP_JCN: begin
          cond = (arg[JCN_ACCZ] && it.accumulator == 4'd0) ||
                 (arg[JCN_CY] && it.carry) || (arg[JCN_TST] && !it.test_pin);
          if (arg[JCN_INV]) cond = !cond;
          if (cond) begin
            nxt = {nxt[11:8], w};
            r.took_jump = 1'b1;
            rel_jump = 1'b1;
          end
        end
        OP_FIM_SRC: begin
          ev = {arg[3:1], 1'b0};
          idx_regs[ev] = w[7:4];
          idx_regs[ev | 4'd1] = w[3:0];
          r.write_kind = WK_PAIR;
          r.target_register = ev;
          r.value_high = w[7:4];
          r.value_low = w[3:0];
        end
        OP_JUN, OP_JMS: begin
          if (op == OP_JMS) begin
            call_stack[call_sp] = nxt;
            call_sp = (call_sp + 1) % STACK_DEPTH;
          end
          nxt = {arg, w};
          r.took_jump = 1'b1;
        end
        OP_ISZ: begin
          v = idx_regs[arg] + 4'd1;
          idx_regs[arg] = v;
          r.write_kind = WK_SINGLE;
          r.target_register = arg;
          r.value_low = v;
          if (v != 4'd0) begin
            nxt = {nxt[11:8], w};
            r.took_jump = 1'b1;
            rel_jump = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      op = w[7:4];
      arg = w[3:0];
      if (op == OP_JCN || op == OP_JUN || op == OP_JMS || op == OP_ISZ ||
          (op == OP_FIM_SRC && !w[0])) begin
        second_due = 1'b1;
        held_first = w;
        r.awaiting_second = 1'b1;
      end else if (op == OP_FIN_JIN && w[0]) begin
        ev = {arg[3:1], 1'b0};
        nxt = {nxt[11:8], idx_regs[ev], idx_regs[ev | 4'd1]};
        r.took_jump = 1'b1;
        rel_jump = 1'b1;
      end else if (op == OP_INC) begin
        v = idx_regs[arg] + 4'd1;
        idx_regs[arg] = v;
        r.write_kind = WK_SINGLE;
        r.target_register = arg;
        r.value_low = v;
      end
    end
    if (r.took_jump) n_jumps++;
    if (rel_jump && pc_q[7:0] == 8'hFF) n_page_end_jumps++;
    if (r.write_kind != WK_NONE) n_reg_writes++;
    pc_q = nxt;
    r.next_address = nxt;
    return r;
  endfunction

  function automatic in_item_t word_item(input logic [7:0] w, input logic [3:0] acc,
                                         input logic cy, input logic tst);
    in_item_t it;
    it.instruction_word = w;
    it.accumulator = acc;
    it.carry = cy;
    it.test_pin = tst;
    return it;
  endfunction

  // random word shaped by the model's decode state; reg_mask narrows operands
  function automatic in_item_t random_item(input logic [3:0] reg_mask);
    in_item_t   it;
    logic [7:0] w;
    w = 8'($urandom);
    if (second_due) begin
      // jump targets near a page end
      if ((held_first[7:4] == OP_JUN || held_first[7:4] == OP_JMS) &&
          $urandom_range(0, 3) == 0)
        w[7:1] = 7'h7F;
    end else if ($urandom_range(0, 99) < 8) begin
      w[7] = 1'b1;
    end else begin
      w[7] = 1'b0;
      w[3:0] = w[3:0] & reg_mask;
    end
    it.instruction_word = w;
    it.accumulator = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
    it.carry = 1'($urandom);
    it.test_pin = 1'($urandom);
    return it;
  endfunction

  task automatic send_word(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_q.push_back(execute_word(it));
    n_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string fname, input logic [15:0] want_v,
                               input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", fname, want_v, got_v);
      n_errors++;
    end
  endtask

  // receiver: stall for a drawn number of cycles ahead of each transfer
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (held_stalled && (out_valid !== 1'b1 || out_item !== held_item)) begin
        $error("out_item: result changed or dropped while stalled");
        n_errors++;
      end
      held_stalled = out_valid && out_stall;
      held_item = out_item;
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          $error("out_item: result with nothing predicted, next_address %0h",
                 out_item.next_address);
          n_errors++;
        end else begin
          want = predicted_q.pop_front();
          compare_field("next_address", 16'(want.next_address), 16'(out_item.next_address));
          compare_field("write_kind", 16'(want.write_kind), 16'(out_item.write_kind));
          compare_field("target_register", 16'(want.target_register),
                        16'(out_item.target_register));
          compare_field("value_high", 16'(want.value_high), 16'(out_item.value_high));
          compare_field("value_low", 16'(want.value_low), 16'(out_item.value_low));
          compare_field("took_jump", 16'(want.took_jump), 16'(out_item.took_jump));
          compare_field("awaiting_second", 16'(want.awaiting_second),
                        16'(out_item.awaiting_second));
          n_checked++;
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 9);
      end
    end
  end

  task automatic test_single_word_ops();
    send_word(word_item(8'h00, 4'h0, 1'b0, 1'b0));  // nop
    send_word(word_item(8'h6F, 4'hF, 1'b1, 1'b1));  // inc r15
    send_word(word_item(8'h21, 4'h5, 1'b0, 1'b1));  // src
    send_word(word_item(8'h30, 4'hA, 1'b1, 1'b0));  // fin
    send_word(word_item(8'h80, 4'h0, 1'b0, 1'b0));
    send_word(word_item(8'hFF, 4'hF, 1'b1, 1'b1));
  endtask

  task automatic test_two_word_ops();
    send_word(word_item(8'h2E, 4'h3, 1'b0, 1'b1));  // fim p7
    send_word(word_item(8'hFF, 4'h3, 1'b0, 1'b1));
    send_word(word_item(8'h6E, 4'h1, 1'b0, 1'b0));  // inc r14 wraps to 0
    send_word(word_item(8'h7F, 4'h1, 1'b0, 1'b0));  // isz r15 wraps, no jump
    send_word(word_item(8'h34, 4'h1, 1'b0, 1'b0));
    send_word(word_item(8'h7F, 4'h2, 1'b1, 1'b1));  // isz r15 to 1, jumps
    send_word(word_item(8'h56, 4'h2, 1'b1, 1'b1));
    send_word(word_item(8'h14, 4'h0, 1'b0, 1'b1));  // jcn on zero accumulator
    send_word(word_item(8'h9A, 4'h0, 1'b0, 1'b1));
    send_word(word_item(8'h1F, 4'h0, 1'b1, 1'b0));  // all true, then inverted
    send_word(word_item(8'hC3, 4'h0, 1'b1, 1'b0));
  endtask

  task automatic test_page_end_targets();
    send_word(word_item(8'h4F, 4'h7, 1'b0, 1'b1));  // jun to 0xffe
    send_word(word_item(8'hFE, 4'h7, 1'b0, 1'b1));
    send_word(word_item(8'h12, 4'h7, 1'b1, 1'b1));  // second word at 0xfff
    send_word(word_item(8'hAB, 4'h7, 1'b1, 1'b1));
    send_word(word_item(8'h5F, 4'h9, 1'b0, 1'b0));  // jms to 0xfff
    send_word(word_item(8'hFF, 4'h9, 1'b0, 1'b0));
    send_word(word_item(8'h3F, 4'h9, 1'b0, 1'b0));  // jin wraps to page 0
  endtask

  task automatic test_random_programs();
    for (int seg = 0; seg < 14; seg++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) drain_results();
      for (int i = 0; i < 100; i++) send_word(random_item(4'hF));
    end
    no_idle = 1'b0;
  endtask

  // back-to-back words on few registers stress the pair read/write path
  task automatic test_drain_and_burst();
    drain_results();
    no_idle = 1'b1;
    stall_left = 0;
    for (int i = 0; i < 200; i++) send_word(random_item(4'h3));
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_single_word_ops();
    test_two_word_ops();
    test_page_end_targets();
    test_random_programs();
    test_drain_and_burst();
    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d instruction words, %0d results checked", n_sent, n_checked);
    $display("%0d jumps taken (%0d page-relative from a page end), %0d register writes",
             n_jumps, n_page_end_jumps, n_reg_writes);
    if (n_errors == 0) begin
      $display("tb_nibble_cpu_jump_and_register_executor: clean");
    end else begin
      $display("tb_nibble_cpu_jump_and_register_executor: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", predicted_q.size());
    $display("tb_nibble_cpu_jump_and_register_executor: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/nibcpu_pkg.sv
rtl/nibcpu_exec.sv
rtl/nibble_cpu_jump_and_register_executor.sv
tb/tb_nibble_cpu_jump_and_register_executor.sv
